// File: hdl/fbc_pkg.sv
`default_nettype none

package fbc_pkg;

   localparam int KEY_W      = 64;
   localparam int HALF_W     = 32;
   localparam int ROUND_W    = 5;
   localparam int ROUND_CNT_W = 7;
   localparam int CSR_IDX_W  = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_CIPHER_KEY  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROUND_COUNT = 8'd1;

   localparam logic [ROUND_W-1:0] ROUND_COUNT_RESET = 5'd10;

   localparam int MIX_ROTL = 9;
   localparam int KEY_ROTR = 11;

   typedef struct packed {
      logic                   valid;
      logic [HALF_W-1:0]      left;
      logic [HALF_W-1:0]      right;
      logic [ROUND_CNT_W-1:0] rounds;
      logic                   decrypt;
   } fbc_beat_type;

   function automatic logic [KEY_W-1:0] rotr64(input logic [KEY_W-1:0] x,
                                               input logic [5:0] amt);
      logic [6:0] back;
      back = 7'd64 - {1'b0, amt};
      return (x >> amt) | (x << back);
   endfunction

endpackage

`default_nettype wire

// File: hdl/feistel_block_cipher_64_unit.sv
// 64-bit feistel block cipher, one round per cell in a chain of MAX_ROUNDS cells
// req channel: one beat carries a 64-bit block and the decrypt flag
// rsp channel: one beat carries the 64-bit result block
// csr channel: index 0 writes the 64-bit key, index 1 the round count (low 5 bits),
// other indexes are ignored; always ready, write only while no block is in flight
// round counts above MAX_ROUNDS act as MAX_ROUNDS, zero passes the block unchanged
// a req beat passes through the register of each of the MAX_ROUNDS cells in turn to reach rsp valid
// throughput: one block per cycle while the receiver does not stall, each cell holds one block and one multiplier
// the last cell register is the output register
// when the receiver stalls, the whole chain holds and req_ready drops only once
// a result is waiting at the output
// reset (synchronous) empties the chain, key goes to 0 and round count to 10
`default_nettype none

module feistel_block_cipher_64_unit
   import fbc_pkg::*;
#(
   parameter int MAX_ROUNDS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [KEY_W-1:0]     req_data_block,
   input  wire logic                 req_decrypt,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [KEY_W-1:0]          rsp_result_block,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [KEY_W-1:0]     csr_data
);

   logic [KEY_W-1:0]       cipher_key_ff;
   logic [ROUND_W-1:0]     round_count_ff;
   logic [ROUND_CNT_W-1:0] rounds;
   logic                   advance;
   fbc_beat_type           chain [MAX_ROUNDS+1];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cipher_key_ff  <= '0;
         round_count_ff <= ROUND_COUNT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CIPHER_KEY:  cipher_key_ff  <= csr_data;
            CSR_ROUND_COUNT: round_count_ff <= csr_data[ROUND_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (int'(round_count_ff) > MAX_ROUNDS) begin
         rounds = ROUND_CNT_W'(MAX_ROUNDS);
      end else begin
         rounds = ROUND_CNT_W'(round_count_ff);
      end
   end

   assign advance   = rsp_ready || !chain[MAX_ROUNDS].valid;
   assign req_ready = advance;

   always_comb begin
      chain[0].valid   = req_valid;
      chain[0].left    = req_data_block[KEY_W-1:HALF_W];
      chain[0].right   = req_data_block[HALF_W-1:0];
      chain[0].rounds  = rounds;
      chain[0].decrypt = req_decrypt;
   end

   for (genvar i = 0; i < MAX_ROUNDS; i++) begin : g_cell
      fbc_cell #(
         .STAGE(i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .cipher_key (cipher_key_ff),
         .beat_in    (chain[i]),
         .beat_out   (chain[i+1])
      );
   end

   assign rsp_valid        = chain[MAX_ROUNDS].valid;
   assign rsp_result_block = {chain[MAX_ROUNDS].left, chain[MAX_ROUNDS].right};

endmodule

`default_nettype wire

// File: hdl/fbc_cell.sv
`default_nettype none

module fbc_cell
   import fbc_pkg::*;
#(
   parameter int STAGE = 0
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire logic [KEY_W-1:0]   cipher_key,
   input  wire fbc_beat_type       beat_in,
   output fbc_beat_type            beat_out
);

   localparam logic [ROUND_CNT_W-1:0] STAGE_CNT = ROUND_CNT_W'(STAGE);

   fbc_beat_type           beat_ff;
   fbc_beat_type           beat_in_next;
   logic                   valid_ff;
   logic                   active;
   logic                   last;
   logic [ROUND_CNT_W-1:0] key_idx;
   logic [ROUND_CNT_W:0]   key_idx_ext;
   logic [ROUND_CNT_W+1:0] rot_sum;
   logic [KEY_W-1:0]       key_rot;
   logic [HALF_W-1:0]      round_key;
   logic [HALF_W-1:0]      mult_key;
   logic [HALF_W-1:0]      prod;
   logic [HALF_W-1:0]      mix_val;
   logic [HALF_W-1:0]      new_right;

   always_comb begin
      active      = beat_in.valid && (STAGE_CNT < beat_in.rounds);
      last        = (STAGE_CNT + ROUND_CNT_W'(1)) == beat_in.rounds;
      key_idx     = beat_in.decrypt ? (beat_in.rounds - ROUND_CNT_W'(1) - STAGE_CNT)
                                    : STAGE_CNT;
      key_idx_ext = {1'b0, key_idx};
      rot_sum     = {key_idx_ext, 1'b0} + {1'b0, key_idx_ext};
      key_rot     = rotr64(cipher_key, rot_sum[5:0]);
      round_key   = key_rot[HALF_W-1:0];
      mult_key    = {round_key[KEY_ROTR-1:0], round_key[HALF_W-1:KEY_ROTR]};
      prod        = mult_key * beat_in.left;
      mix_val     = {beat_in.left[HALF_W-1-MIX_ROTL:0],
                     beat_in.left[HALF_W-1:HALF_W-MIX_ROTL]} ^ ~prod;
      new_right   = beat_in.right ^ mix_val;

      beat_in_next = beat_in;
      if (active) begin
         if (last) begin
            beat_in_next.right = new_right;
         end else begin
            beat_in_next.left  = new_right;
            beat_in_next.right = beat_in.left;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= beat_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         beat_ff <= beat_in_next;
      end
   end

   always_comb begin
      beat_out       = beat_ff;
      beat_out.valid = valid_ff;
   end

endmodule

`default_nettype wire
